/* design/bbd_pkg.sv */
// ----------------------------------------------------------------------------
// Bayer demosaic package
// Shared sizes, register indexes and the job type that passes from the
// front part to the interpolation back part.
// ----------------------------------------------------------------------------
package bbd_pkg;

  localparam int MAX_LINE_PIXELS = 1024;
  localparam int PIXEL_BITS      = 8;
  localparam int MAX_ROWS        = 4096;
  localparam int MIN_SIZE        = 2;

  localparam int COL_BITS    = $clog2(MAX_LINE_PIXELS);
  localparam int ROW_BITS    = $clog2(MAX_ROWS);
  localparam int WIDTH_BITS  = 11;
  localparam int HEIGHT_BITS = 13;

  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 13;

  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd390;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd300;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef logic [PIXEL_BITS-1:0] pixel_t;

  // One job covers every result that one input item causes.
  typedef struct packed {
    pixel_t [2:0][2:0] win;
    logic              last_row;
    logic              last_col;
    logic              top_edge;
    logic              left_edge;
    logic              row_odd;
    logic              col_odd;
  } bbd_job_t;

endpackage

/* design/bayer_bilinear_demosaic.sv */
// ----------------------------------------------------------------------------
// Bilinear Bayer demosaic, GRBG
// Streams raw pixels in raster order and returns one RGB result per site.
// ----------------------------------------------------------------------------
// The block takes one raw pixel per clock inside the frame and gives out at
// most one result per clock. An item inside the frame gives the result of the
// site one row up and one column left. An item in the last column also gives
// that row's last site, and items of the last row also give the sites of the
// last row, so such an item causes two or four results. A four-entry job
// queue absorbs these bursts, and in_stall rises only when the queue is full.
// Across the last row every item but the one in column 0 causes at least two
// results, so once the queue has filled the output sets the pace and the
// input takes items only as fast as their results drain. The first result
// of an item passes the stage that holds the registered read of the two
// 1024 x 8 line stores, one job-queue entry and the output register. The
// line stores need no clearing.
module bayer_bilinear_demosaic (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [bbd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [bbd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [bbd_pkg::PIXEL_BITS-1:0]     in_raw_pixel,
  input  logic                               in_frame_start,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [bbd_pkg::PIXEL_BITS-1:0]     out_red,
  output logic [bbd_pkg::PIXEL_BITS-1:0]     out_green,
  output logic [bbd_pkg::PIXEL_BITS-1:0]     out_blue,
  output logic                               out_end_of_line,
  output logic                               out_end_of_frame,
  output logic                               out_last_of_run
);

  logic              q_push, q_full, q_pop, q_valid;
  bbd_pkg::bbd_job_t push_job, head_job;

  bbd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_raw_pixel   (in_raw_pixel),
    .in_frame_start (in_frame_start),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_job          (push_job)
  );

  bbd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (head_job)
  );

  bbd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .job_valid        (q_valid),
    .job              (head_job),
    .job_pop          (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_end_of_line  (out_end_of_line),
    .out_end_of_frame (out_end_of_frame),
    .out_last_of_run  (out_last_of_run)
  );

  a_eof_is_eol: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_frame |-> out_end_of_line)
    else $error("end of frame outside the last column");

  a_eof_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_frame |-> out_last_of_run)
    else $error("end of frame is not the last result of its item");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !q_valid |-> !in_stall)
    else $error("input stalled while the job queue is empty");

endmodule

/* design/bbd_front.sv */
// ----------------------------------------------------------------------------
// Bayer demosaic front part
// Holds the size registers, position counters, the two line stores and the
// 3x3 window, and makes a job for each accepted item past row 0 and column 0.
// ----------------------------------------------------------------------------
module bbd_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [bbd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [bbd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [bbd_pkg::PIXEL_BITS-1:0]     in_raw_pixel,
  input  logic                               in_frame_start,
  input  logic                               q_full,
  output logic                               q_push,
  output bbd_pkg::bbd_job_t                  q_job
);

  logic [bbd_pkg::WIDTH_BITS-1:0]  act_w_r;
  logic [bbd_pkg::HEIGHT_BITS-1:0] act_h_r;
  logic [bbd_pkg::WIDTH_BITS-1:0]  w_in, w_cl;
  logic [bbd_pkg::HEIGHT_BITS-1:0] h_in, h_cl;

  logic [bbd_pkg::COL_BITS-1:0] col_r, col_nxt, col_s;
  logic [bbd_pkg::ROW_BITS-1:0] row_r, row_nxt, row_s;
  logic [bbd_pkg::WIDTH_BITS-1:0]  col_inc;
  logic [bbd_pkg::HEIGHT_BITS-1:0] row_inc;
  logic last_col_s, last_row_s, accept;

  bbd_pkg::pixel_t older_line_r [bbd_pkg::MAX_LINE_PIXELS];
  bbd_pkg::pixel_t newer_line_r [bbd_pkg::MAX_LINE_PIXELS];
  bbd_pkg::pixel_t rd_old_r, rd_new_r, fwd_old_r, fwd_new_r;
  bbd_pkg::pixel_t b_old_eff, b_new_eff, b_px_r;
  logic            fwd_r;

  logic                         b_valid_r, b_valid_nxt, b_go;
  logic [bbd_pkg::COL_BITS-1:0] b_col_r;
  logic b_emit_r, b_last_row_r, b_last_col_r, b_top_r, b_left_r, b_rodd_r, b_codd_r;

  bbd_pkg::pixel_t [2:0][2:0] win_r, win_nxt;

  always_comb begin
    w_in = cfg_data[bbd_pkg::WIDTH_BITS-1:0];
    h_in = cfg_data[bbd_pkg::HEIGHT_BITS-1:0];
    w_cl = w_in;
    h_cl = h_in;
    if (w_in < bbd_pkg::WIDTH_BITS'(bbd_pkg::MIN_SIZE)) begin
      w_cl = bbd_pkg::WIDTH_BITS'(bbd_pkg::MIN_SIZE);
    end else if (w_in > bbd_pkg::WIDTH_BITS'(bbd_pkg::MAX_LINE_PIXELS)) begin
      w_cl = bbd_pkg::WIDTH_BITS'(bbd_pkg::MAX_LINE_PIXELS);
    end
    if (h_in < bbd_pkg::HEIGHT_BITS'(bbd_pkg::MIN_SIZE)) begin
      h_cl = bbd_pkg::HEIGHT_BITS'(bbd_pkg::MIN_SIZE);
    end else if (h_in > bbd_pkg::HEIGHT_BITS'(bbd_pkg::MAX_ROWS)) begin
      h_cl = bbd_pkg::HEIGHT_BITS'(bbd_pkg::MAX_ROWS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_w_r <= bbd_pkg::WIDTH_RESET;
      act_h_r <= bbd_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bbd_pkg::REG_FRAME_WIDTH:  act_w_r <= w_cl;
        bbd_pkg::REG_FRAME_HEIGHT: act_h_r <= h_cl;
        default: ;
      endcase
    end
  end

  always_comb begin
    col_s = in_frame_start ? '0 : col_r;
    row_s = in_frame_start ? '0 : row_r;
    if ({1'b0, col_s} >= act_w_r) begin
      col_s = '0;
    end
    if ({1'b0, row_s} >= act_h_r) begin
      row_s = '0;
    end
    col_inc    = {1'b0, col_s} + bbd_pkg::WIDTH_BITS'(1);
    row_inc    = {1'b0, row_s} + bbd_pkg::HEIGHT_BITS'(1);
    last_col_s = (col_inc == act_w_r);
    last_row_s = (row_inc == act_h_r);
    col_nxt    = last_col_s ? '0 : col_inc[bbd_pkg::COL_BITS-1:0];
    row_nxt    = row_s;
    if (last_col_s) begin
      row_nxt = last_row_s ? '0 : row_inc[bbd_pkg::ROW_BITS-1:0];
    end
  end

  assign b_go     = b_valid_r && (!b_emit_r || !q_full);
  assign in_stall = b_valid_r && !b_go;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    b_valid_nxt = b_valid_r;
    if (accept) begin
      b_valid_nxt = 1'b1;
    end else if (b_go) begin
      b_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= b_valid_nxt;
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_col_r      <= col_s;
      b_px_r       <= in_raw_pixel;
      b_emit_r     <= (row_s != '0) && (col_s != '0);
      b_last_row_r <= last_row_s;
      b_last_col_r <= last_col_s;
      b_top_r      <= (row_s == bbd_pkg::ROW_BITS'(1));
      b_left_r     <= (col_s == bbd_pkg::COL_BITS'(1));
      b_rodd_r     <= ~row_s[0];
      b_codd_r     <= ~col_s[0];
      fwd_r        <= b_go && (b_col_r == col_s);
      fwd_old_r    <= b_new_eff;
      fwd_new_r    <= b_px_r;
    end
  end

  // The line stores are read when an item is taken and written when it
  // leaves; a write to the address being read is forwarded.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_old_r <= older_line_r[col_s];
      rd_new_r <= newer_line_r[col_s];
    end
    if (b_go) begin
      older_line_r[b_col_r] <= b_new_eff;
      newer_line_r[b_col_r] <= b_px_r;
    end
  end

  assign b_old_eff = fwd_r ? fwd_old_r : rd_old_r;
  assign b_new_eff = fwd_r ? fwd_new_r : rd_new_r;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r][0] = win_r[r][1];
      win_nxt[r][1] = win_r[r][2];
    end
    win_nxt[0][2] = b_old_eff;
    win_nxt[1][2] = b_new_eff;
    win_nxt[2][2] = b_px_r;
  end

  always_ff @(posedge clk) begin
    if (b_go) begin
      win_r <= win_nxt;
    end
  end

  assign q_push          = b_go && b_emit_r;
  assign q_job.win       = win_nxt;
  assign q_job.last_row  = b_last_row_r;
  assign q_job.last_col  = b_last_col_r;
  assign q_job.top_edge  = b_top_r;
  assign q_job.left_edge = b_left_r;
  assign q_job.row_odd   = b_rodd_r;
  assign q_job.col_odd   = b_codd_r;

endmodule

/* design/bbd_queue.sv */
// ----------------------------------------------------------------------------
// Bayer demosaic job queue
// A short first-in first-out queue of jobs between the front and back parts.
// ----------------------------------------------------------------------------
module bbd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bbd_pkg::bbd_job_t push_job,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output bbd_pkg::bbd_job_t head_job
);

  bbd_pkg::bbd_job_t entry_r [bbd_pkg::QUEUE_DEPTH];
  logic [bbd_pkg::QPTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [bbd_pkg::QCNT_BITS-1:0] count_r, count_nxt;
  logic do_push, do_pop;

  assign full       = (count_r == bbd_pkg::QCNT_BITS'(bbd_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = entry_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + bbd_pkg::QCNT_BITS'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - bbd_pkg::QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + bbd_pkg::QPTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + bbd_pkg::QPTR_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

/* design/bbd_back.sv */
// ----------------------------------------------------------------------------
// Bayer demosaic back part
// Steps through the one, two or four sites of each job, interpolates the
// missing colors and holds each result in the output register.
// ----------------------------------------------------------------------------
module bbd_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           job_valid,
  input  bbd_pkg::bbd_job_t              job,
  output logic                           job_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bbd_pkg::PIXEL_BITS-1:0] out_red,
  output logic [bbd_pkg::PIXEL_BITS-1:0] out_green,
  output logic [bbd_pkg::PIXEL_BITS-1:0] out_blue,
  output logic                           out_end_of_line,
  output logic                           out_end_of_frame,
  output logic                           out_last_of_run
);

  localparam int SUM2_BITS = bbd_pkg::PIXEL_BITS + 1;
  localparam int SUM4_BITS = bbd_pkg::PIXEL_BITS + 2;

  logic [1:0] k_r, k_nxt;
  logic       bot, rgt, last, load;
  logic [1:0] cr, cc, up, dn, lf, rt;
  logic       odd_row, odd_col;
  logic [SUM2_BITS-1:0] hor, ver;
  logic [SUM4_BITS-1:0] dia, hv;
  bbd_pkg::pixel_t ctr, red_s, green_s, blue_s;
  logic out_valid_r, out_valid_nxt;
  bbd_pkg::pixel_t red_r, green_r, blue_r;
  logic eol_r, eof_r, lor_r;

  always_comb begin
    bot  = job.last_row ? k_r[0] : 1'b0;
    rgt  = job.last_row ? k_r[1] : k_r[0];
    last = (bot == job.last_row) && (rgt == job.last_col);
    cr   = bot ? 2'd2 : 2'd1;
    cc   = rgt ? 2'd2 : 2'd1;
    up   = bot ? 2'd1 : (job.top_edge ? 2'd2 : 2'd0);
    dn   = bot ? 2'd1 : 2'd2;
    lf   = rgt ? 2'd1 : (job.left_edge ? 2'd2 : 2'd0);
    rt   = rgt ? 2'd1 : 2'd2;
    odd_row = bot ? ~job.row_odd : job.row_odd;
    odd_col = rgt ? ~job.col_odd : job.col_odd;
    ctr  = job.win[cr][cc];
    hor  = {1'b0, job.win[cr][lf]} + {1'b0, job.win[cr][rt]};
    ver  = {1'b0, job.win[up][cc]} + {1'b0, job.win[dn][cc]};
    dia  = SUM4_BITS'({1'b0, job.win[up][lf]} + {1'b0, job.win[up][rt]})
         + SUM4_BITS'({1'b0, job.win[dn][lf]} + {1'b0, job.win[dn][rt]});
    hv   = SUM4_BITS'(hor) + SUM4_BITS'(ver);
    unique case ({odd_row, odd_col})
      2'b00: begin
        red_s   = hor[SUM2_BITS-1:1];
        green_s = ctr;
        blue_s  = ver[SUM2_BITS-1:1];
      end
      2'b01: begin
        red_s   = ctr;
        green_s = hv[SUM4_BITS-1:2];
        blue_s  = dia[SUM4_BITS-1:2];
      end
      2'b10: begin
        red_s   = dia[SUM4_BITS-1:2];
        green_s = hv[SUM4_BITS-1:2];
        blue_s  = ctr;
      end
      default: begin
        red_s   = ver[SUM2_BITS-1:1];
        green_s = ctr;
        blue_s  = hor[SUM2_BITS-1:1];
      end
    endcase
  end

  assign load    = job_valid && (!out_valid_r || !out_stall);
  assign job_pop = load && last;

  always_comb begin
    k_nxt = k_r;
    if (load) begin
      k_nxt = last ? 2'd0 : k_r + 2'd1;
    end
    out_valid_nxt = out_valid_r && out_stall;
    if (load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      red_r   <= red_s;
      green_r <= green_s;
      blue_r  <= blue_s;
      eol_r   <= rgt;
      eof_r   <= rgt && bot;
      lor_r   <= last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_red          = red_r;
  assign out_green        = green_r;
  assign out_blue         = blue_r;
  assign out_end_of_line  = eol_r;
  assign out_end_of_frame = eof_r;
  assign out_last_of_run  = lor_r;

endmodule

/* verif/bayer_bilinear_demosaic_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear Bayer demosaic testbench
// Streams raw GRBG pixels through the block with random gaps on both channels
// and checks every RGB site against a line-store predictor. Sizes are changed
// between frames, out-of-range sizes included, and a short table of small
// frames follows a few pixels at the reset size.
// ----------------------------------------------------------------------------
module bayer_bilinear_demosaic_tb;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RESET_ITEMS   = 6;
  localparam int WIDE_ITEMS    = 12;
  localparam int RANDOM_ITEMS  = 110;
  localparam int DIRECTED_LEN  = 22;

  typedef struct packed {
    bbd_pkg::pixel_t red;
    bbd_pkg::pixel_t green;
    bbd_pkg::pixel_t blue;
    logic            eol;
    logic            eof;
    logic            last;
  } rgb_site_t;

  typedef struct packed {
    bbd_pkg::pixel_t px;
    logic            fs;
    logic            typed;
    bbd_pkg::pixel_t color;
  } pixel_row_t;

  // The table runs at a 2 x 2 frame. Flat frames give flat sites.
  localparam pixel_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
    '{8'hFF, 1'b1, 1'b1, 8'hFF}, '{8'hFF, 1'b0, 1'b1, 8'hFF},
    '{8'hFF, 1'b0, 1'b1, 8'hFF}, '{8'hFF, 1'b0, 1'b1, 8'hFF},
    '{8'h00, 1'b0, 1'b1, 8'h00}, '{8'h00, 1'b0, 1'b1, 8'h00},
    '{8'h00, 1'b0, 1'b1, 8'h00}, '{8'h00, 1'b0, 1'b1, 8'h00},
    '{8'd10, 1'b1, 1'b0, 8'h00}, '{8'd200, 1'b0, 1'b0, 8'h00},
    '{8'd37, 1'b0, 1'b0, 8'h00}, '{8'd99, 1'b0, 1'b0, 8'h00},
    '{8'd5, 1'b0, 1'b0, 8'h00}, '{8'd250, 1'b0, 1'b0, 8'h00},
    '{8'd1, 1'b1, 1'b0, 8'h00}, '{8'd128, 1'b0, 1'b0, 8'h00},
    '{8'd127, 1'b0, 1'b0, 8'h00}, '{8'd254, 1'b0, 1'b0, 8'h00},
    '{8'hFF, 1'b1, 1'b0, 8'h00}, '{8'h00, 1'b0, 1'b0, 8'h00},
    '{8'h00, 1'b0, 1'b0, 8'h00}, '{8'hFF, 1'b0, 1'b0, 8'h00}
  };

  logic                              clk            = 1'b0;
  logic                              rst_n          = 1'b0;
  logic                              cfg_we         = 1'b0;
  logic [bbd_pkg::CFG_IDX_BITS-1:0]  cfg_index      = '0;
  logic [bbd_pkg::CFG_DATA_BITS-1:0] cfg_data       = '0;
  logic                              in_valid       = 1'b0;
  bbd_pkg::pixel_t                   in_raw_pixel   = '0;
  logic                              in_frame_start = 1'b0;
  logic                              out_stall      = 1'b0;
  logic                              in_stall;
  logic                              out_valid;
  bbd_pkg::pixel_t                   out_red;
  bbd_pkg::pixel_t                   out_green;
  bbd_pkg::pixel_t                   out_blue;
  logic                              out_end_of_line;
  logic                              out_end_of_frame;
  logic                              out_last_of_run;

  bbd_pkg::pixel_t                   older_row [bbd_pkg::MAX_LINE_PIXELS];
  bbd_pkg::pixel_t                   newer_row [bbd_pkg::MAX_LINE_PIXELS];
  bbd_pkg::pixel_t                   win [3][3];
  int unsigned                       row_pos;
  int unsigned                       col_pos;
  logic [bbd_pkg::WIDTH_BITS-1:0]    width_reg  = bbd_pkg::WIDTH_RESET;
  logic [bbd_pkg::HEIGHT_BITS-1:0]   height_reg = bbd_pkg::HEIGHT_RESET;
  rgb_site_t                         rgb_due [$];
  rgb_site_t                         due;

  int          fail_count    = 0;
  int          items_sent    = 0;
  int          sites_checked = 0;
  int          phase_count   = 0;
  int unsigned rx_wait       = 0;
  int unsigned idle_cycles   = 0;
  bit          tx_burst      = 1'b0;
  bit          rx_burst      = 1'b0;

  bayer_bilinear_demosaic u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_raw_pixel     (in_raw_pixel),
    .in_frame_start   (in_frame_start),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_end_of_line  (out_end_of_line),
    .out_end_of_frame (out_end_of_frame),
    .out_last_of_run  (out_last_of_run)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int idle_draw(inout bit burst);
    if ($urandom_range(0, 24) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic bbd_pkg::pixel_t random_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return bbd_pkg::pixel_t'($urandom);
    endcase
  endfunction

  function automatic int unsigned window_tap(int wr, int wc, int unsigned tr, int unsigned tc,
                                             int unsigned aw, int unsigned ah, int dr, int dc);
    int r;
    int c;
    if (tr == 0 && dr < 0) dr = 1;
    if (tr + 1 >= ah && dr > 0) dr = -1;
    if (tc == 0 && dc < 0) dc = 1;
    if (tc + 1 >= aw && dc > 0) dc = -1;
    r = wr + dr;
    c = wc + dc;
    if (r < 0 || r > 2 || c < 0 || c > 2) return 0;
    return win[r][c];
  endfunction

  function automatic rgb_site_t site_rgb(int wr, int wc, int unsigned tr, int unsigned tc,
                                         int unsigned aw, int unsigned ah);
    int unsigned ctr;
    int unsigned hor;
    int unsigned ver;
    int unsigned dia;
    int unsigned r;
    int unsigned g;
    int unsigned b;
    rgb_site_t   s;
    ctr = window_tap(wr, wc, tr, tc, aw, ah, 0, 0);
    hor = window_tap(wr, wc, tr, tc, aw, ah, 0, -1) + window_tap(wr, wc, tr, tc, aw, ah, 0, 1);
    ver = window_tap(wr, wc, tr, tc, aw, ah, -1, 0) + window_tap(wr, wc, tr, tc, aw, ah, 1, 0);
    dia = window_tap(wr, wc, tr, tc, aw, ah, -1, -1) + window_tap(wr, wc, tr, tc, aw, ah, -1, 1)
        + window_tap(wr, wc, tr, tc, aw, ah, 1, -1) + window_tap(wr, wc, tr, tc, aw, ah, 1, 1);
    if (tr % 2 == 0 && tc % 2 == 0) begin
      r = hor / 2;
      g = ctr;
      b = ver / 2;
    end else if (tr % 2 == 0) begin
      r = ctr;
      g = (hor + ver) / 4;
      b = dia / 4;
    end else if (tc % 2 == 0) begin
      r = dia / 4;
      g = (hor + ver) / 4;
      b = ctr;
    end else begin
      r = ver / 2;
      g = ctr;
      b = hor / 2;
    end
    s.red   = bbd_pkg::pixel_t'(r);
    s.green = bbd_pkg::pixel_t'(g);
    s.blue  = bbd_pkg::pixel_t'(b);
    s.eol   = (tc + 1 == aw);
    s.eof   = (tc + 1 == aw) && (tr + 1 == ah);
    s.last  = 1'b0;
    return s;
  endfunction

  function automatic void predict_sites(bbd_pkg::pixel_t px, logic fs, logic typed,
                                        bbd_pkg::pixel_t color);
    int unsigned aw;
    int unsigned ah;
    int unsigned col;
    int unsigned row;
    rgb_site_t   burst_sites [$];
    aw = width_reg;
    if (aw < bbd_pkg::MIN_SIZE) aw = bbd_pkg::MIN_SIZE;
    if (aw > bbd_pkg::MAX_LINE_PIXELS) aw = bbd_pkg::MAX_LINE_PIXELS;
    ah = height_reg;
    if (ah < bbd_pkg::MIN_SIZE) ah = bbd_pkg::MIN_SIZE;
    if (ah > bbd_pkg::MAX_ROWS) ah = bbd_pkg::MAX_ROWS;
    if (fs) begin
      row_pos = 0;
      col_pos = 0;
    end
    if (col_pos >= aw) col_pos = 0;
    if (row_pos >= ah) row_pos = 0;
    col = col_pos;
    row = row_pos;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = older_row[col];
    win[1][2] = newer_row[col];
    win[2][2] = px;
    older_row[col] = newer_row[col];
    newer_row[col] = px;
    if (row >= 1 && col >= 1) begin
      burst_sites.push_back(site_rgb(1, 1, row - 1, col - 1, aw, ah));
      if (row + 1 == ah) burst_sites.push_back(site_rgb(2, 1, row, col - 1, aw, ah));
      if (col + 1 == aw) begin
        burst_sites.push_back(site_rgb(1, 2, row - 1, col, aw, ah));
        if (row + 1 == ah) burst_sites.push_back(site_rgb(2, 2, row, col, aw, ah));
      end
    end
    foreach (burst_sites[k]) begin
      if (typed) begin
        burst_sites[k].red   = color;
        burst_sites[k].green = color;
        burst_sites[k].blue  = color;
      end
      burst_sites[k].last = (k == burst_sites.size() - 1);
      rgb_due.push_back(burst_sites[k]);
    end
    col_pos = col + 1;
    if (col_pos >= aw) begin
      col_pos = 0;
      row_pos = row + 1;
      if (row_pos >= ah) row_pos = 0;
    end
  endfunction

  task automatic write_reg(logic [bbd_pkg::CFG_IDX_BITS-1:0] idx,
                           logic [bbd_pkg::CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (idx == bbd_pkg::REG_FRAME_WIDTH) width_reg = data[bbd_pkg::WIDTH_BITS-1:0];
    else height_reg = data[bbd_pkg::HEIGHT_BITS-1:0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_pixel(bbd_pkg::pixel_t px, logic fs, logic typed, bbd_pkg::pixel_t color);
    int gap;
    gap = idle_draw(tx_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_raw_pixel   <= px;
    in_frame_start <= fs;
    do @(posedge clk); while (in_stall);
    predict_sites(px, fs, typed, color);
    items_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (rgb_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(logic [bbd_pkg::CFG_DATA_BITS-1:0] wdata,
                              logic [bbd_pkg::CFG_DATA_BITS-1:0] hdata,
                              int items, bit noisy, bit hold_mid);
    write_reg(bbd_pkg::REG_FRAME_WIDTH, wdata);
    write_reg(bbd_pkg::REG_FRAME_HEIGHT, hdata);
    for (int i = 0; i < items; i++) begin
      if (hold_mid && i == items / 2) settle();
      send_pixel(random_pixel(), (i == 0) || (noisy && $urandom_range(0, 39) == 0), 1'b0, '0);
    end
    settle();
    phase_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (rgb_due.size() == 0) begin
        $error("unexpected result: red %0d green %0d blue %0d", out_red, out_green, out_blue);
        fail_count++;
      end else begin
        due = rgb_due.pop_front();
        sites_checked++;
        if (out_red !== due.red) begin
          $error("red: expected %0d, got %0d", due.red, out_red);
          fail_count++;
        end
        if (out_green !== due.green) begin
          $error("green: expected %0d, got %0d", due.green, out_green);
          fail_count++;
        end
        if (out_blue !== due.blue) begin
          $error("blue: expected %0d, got %0d", due.blue, out_blue);
          fail_count++;
        end
        if (out_end_of_line !== due.eol) begin
          $error("end_of_line: expected %0d, got %0d", due.eol, out_end_of_line);
          fail_count++;
        end
        if (out_end_of_frame !== due.eof) begin
          $error("end_of_frame: expected %0d, got %0d", due.eof, out_end_of_frame);
          fail_count++;
        end
        if (out_last_of_run !== due.last) begin
          $error("last_of_run: expected %0d, got %0d", due.last, out_last_of_run);
          fail_count++;
        end
      end
      rx_wait = idle_draw(rx_burst);
    end else if (rx_wait > 0) begin
      rx_wait--;
    end
    out_stall <= (rx_wait != 0);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int wv;
    int hv;
    int wc;
    int hc;
    int n;
    int random_items;
    for (int i = 0; i < bbd_pkg::MAX_LINE_PIXELS; i++) begin
      older_row[i] = '0;
      newer_row[i] = '0;
    end
    foreach (win[r, c]) win[r][c] = '0;
    row_pos = 0;
    col_pos = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // At the reset width the first row gives no sites.
    for (int i = 0; i < RESET_ITEMS; i++) send_pixel(random_pixel(), i == 0, 1'b0, '0);
    settle();
    phase_count++;

    write_reg(bbd_pkg::REG_FRAME_WIDTH, 13'd1);
    write_reg(bbd_pkg::REG_FRAME_HEIGHT, 13'd0);
    foreach (DIRECTED_ROWS[i]) begin
      send_pixel(DIRECTED_ROWS[i].px, DIRECTED_ROWS[i].fs, DIRECTED_ROWS[i].typed,
                 DIRECTED_ROWS[i].color);
    end
    settle();
    phase_count++;

    random_phase(13'h07FF, 13'd2, WIDE_ITEMS, 1'b0, 1'b0);
    random_phase(13'd5, 13'h1FFF, 17, 1'b0, 1'b1);

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      wv = $urandom_range(0, 9);
      hv = $urandom_range(0, 6);
      wc = (wv < bbd_pkg::MIN_SIZE) ? bbd_pkg::MIN_SIZE : wv;
      hc = (hv < bbd_pkg::MIN_SIZE) ? bbd_pkg::MIN_SIZE : hv;
      n  = $urandom_range(1, 3) * wc * hc;
      if ($urandom_range(0, 2) == 0) n -= $urandom_range(0, wc);
      if (n > RANDOM_ITEMS - random_items) n = RANDOM_ITEMS - random_items;
      random_phase({2'($urandom), 11'(wv)}, 13'(hv), n, 1'b1, 1'b0);
      random_items += n;
    end

    $display("Sent %0d pixels over %0d size settings: reset size, clamped sizes, small frames.",
             items_sent, phase_count);
    $display("Checked %0d RGB sites, %0d mismatches.", sites_checked, fail_count);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

/* files.f */
design/bbd_pkg.sv
design/bbd_front.sv
design/bbd_queue.sv
design/bbd_back.sv
design/bayer_bilinear_demosaic.sv
verif/bayer_bilinear_demosaic_tb.sv
